// File: design/siws_pkg.sv
// Shared types and constants for the sorted-index weighted sum block.
// Used by the controller, the datapath and the top level; no dependencies.
package siws_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = ADDR_W + 1;
  localparam int VAL_W = 31;
  localparam int SUM_W = 30;
  localparam int PROD_W = VAL_W + ADDR_W;
  localparam int ACC_W = PROD_W + ADDR_W;
  localparam int RED_TOP = ACC_W - SUM_W;
  localparam int RED_W = $clog2(RED_TOP + 1);
  localparam logic [SUM_W-1:0] MODULUS = SUM_W'(1000000007);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SUM_INIT,
    ST_SUM_RD,
    ST_SUM_MUL,
    ST_SUM_ACC,
    ST_RED,
    ST_OUT
  } siws_state_t;

  typedef struct packed {
    logic load;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic sum_init;
    logic sum_rd;
    logic sum_mul;
    logic sum_acc;
    logic red_step;
    logic out_load;
  } siws_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic pos_zero;
    logic rdata_gt;
    logic idx_done;
    logic red_done;
    logic out_busy;
  } siws_stat_t;

endpackage

// File: design/siws_ctrl.sv
// Controller state machine for the sorted-index weighted sum block.
// Depends on siws_pkg; drives the datapath through siws_cmd_t.
module siws_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  in_last,
  input  siws_pkg::siws_stat_t  stat,
  output logic                  in_tready,
  output siws_pkg::siws_cmd_t   cmd
);

  siws_pkg::siws_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= siws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      siws_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!stat.full) begin
            state_nxt = siws_pkg::ST_INS_RD;
          end else if (in_last) begin
            state_nxt = siws_pkg::ST_SUM_INIT;
          end
        end
      end
      siws_pkg::ST_INS_RD: begin
        if (stat.pos_zero) begin
          state_nxt = stat.last ? siws_pkg::ST_SUM_INIT : siws_pkg::ST_IDLE;
        end else begin
          state_nxt = siws_pkg::ST_INS_CMP;
        end
      end
      siws_pkg::ST_INS_CMP: begin
        if (stat.rdata_gt) begin
          state_nxt = siws_pkg::ST_INS_RD;
        end else begin
          state_nxt = stat.last ? siws_pkg::ST_SUM_INIT : siws_pkg::ST_IDLE;
        end
      end
      siws_pkg::ST_SUM_INIT: state_nxt = siws_pkg::ST_SUM_RD;
      siws_pkg::ST_SUM_RD: begin
        state_nxt = stat.idx_done ? siws_pkg::ST_RED : siws_pkg::ST_SUM_MUL;
      end
      siws_pkg::ST_SUM_MUL: state_nxt = siws_pkg::ST_SUM_ACC;
      siws_pkg::ST_SUM_ACC: state_nxt = siws_pkg::ST_SUM_RD;
      siws_pkg::ST_RED: begin
        if (stat.red_done) begin
          state_nxt = siws_pkg::ST_OUT;
        end
      end
      siws_pkg::ST_OUT: begin
        if (!stat.out_busy) begin
          state_nxt = siws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = siws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      siws_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load = in_fire;
      end
      siws_pkg::ST_INS_RD: begin
        cmd.ins_place = stat.pos_zero;
        cmd.ins_rd = !stat.pos_zero;
      end
      siws_pkg::ST_INS_CMP: begin
        cmd.ins_shift = stat.rdata_gt;
        cmd.ins_place = !stat.rdata_gt;
      end
      siws_pkg::ST_SUM_INIT: cmd.sum_init = 1'b1;
      siws_pkg::ST_SUM_RD: cmd.sum_rd = !stat.idx_done;
      siws_pkg::ST_SUM_MUL: cmd.sum_mul = 1'b1;
      siws_pkg::ST_SUM_ACC: cmd.sum_acc = 1'b1;
      siws_pkg::ST_RED: cmd.red_step = 1'b1;
      siws_pkg::ST_OUT: cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/siws_dp.sv
// Datapath for the sorted-index weighted sum block: sorted store memory,
// insertion pointer, multiply-accumulate, modular reduction and output register.
// Depends on siws_pkg; controlled by siws_ctrl.
module siws_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  siws_pkg::siws_cmd_t           cmd,
  input  logic [siws_pkg::VAL_W-1:0]    in_value,
  input  logic                          in_last,
  input  logic                          out_tready,
  output siws_pkg::siws_stat_t          stat,
  output logic                          out_tvalid,
  output logic [siws_pkg::SUM_W-1:0]    out_sum,
  output logic                          out_ovf
);

  logic [siws_pkg::VAL_W-1:0]  mem [siws_pkg::MAX_ELEMENTS];
  logic [siws_pkg::VAL_W-1:0]  rdata_r;
  logic [siws_pkg::VAL_W-1:0]  val_r;
  logic                        last_r;
  logic [siws_pkg::CNT_W-1:0]  count_r;
  logic                        ovf_r;
  logic [siws_pkg::CNT_W-1:0]  pos_r;
  logic [siws_pkg::CNT_W-1:0]  idx_r;
  logic [siws_pkg::PROD_W-1:0] prod_r;
  logic [siws_pkg::ACC_W-1:0]  acc_r;
  logic [siws_pkg::RED_W-1:0]  k_r;
  logic                        out_valid_r;
  logic [siws_pkg::SUM_W-1:0]  out_sum_r;
  logic                        out_ovf_r;
  logic [siws_pkg::ADDR_W-1:0] rd_addr;
  logic [siws_pkg::CNT_W-1:0]  pos_dec;
  logic [siws_pkg::ACC_W-1:0]  mod_shift;
  logic                        full;

  assign full = (count_r == siws_pkg::CNT_W'(siws_pkg::MAX_ELEMENTS));
  assign pos_dec = pos_r - siws_pkg::CNT_W'(1);
  assign rd_addr = cmd.ins_rd ? pos_dec[siws_pkg::ADDR_W-1:0]
                              : idx_r[siws_pkg::ADDR_W-1:0];
  assign mod_shift = siws_pkg::ACC_W'(siws_pkg::MODULUS) << k_r;

  always_ff @(posedge clk) begin
    if (cmd.ins_rd || cmd.sum_rd) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.ins_shift) begin
      mem[pos_r[siws_pkg::ADDR_W-1:0]] <= rdata_r;
    end else if (cmd.ins_place) begin
      mem[pos_r[siws_pkg::ADDR_W-1:0]] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value;
      last_r <= in_last;
      pos_r <= count_r;
    end else if (cmd.ins_shift) begin
      pos_r <= pos_dec;
    end
    if (cmd.sum_init) begin
      idx_r <= '0;
      acc_r <= '0;
      k_r <= siws_pkg::RED_W'(siws_pkg::RED_TOP);
    end else if (cmd.sum_acc) begin
      acc_r <= acc_r + siws_pkg::ACC_W'(prod_r);
      idx_r <= idx_r + siws_pkg::CNT_W'(1);
    end else if (cmd.red_step) begin
      if (acc_r >= mod_shift) begin
        acc_r <= acc_r - mod_shift;
      end
      k_r <= k_r - siws_pkg::RED_W'(1);
    end
    if (cmd.sum_mul) begin
      prod_r <= siws_pkg::PROD_W'(rdata_r) *
                siws_pkg::PROD_W'(idx_r[siws_pkg::ADDR_W-1:0]);
    end
    if (cmd.out_load) begin
      out_sum_r <= acc_r[siws_pkg::SUM_W-1:0];
      out_ovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        count_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        if (cmd.load && full) begin
          ovf_r <= 1'b1;
        end
        if (cmd.ins_place) begin
          count_r <= count_r + siws_pkg::CNT_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.full = full;
    stat.last = last_r;
    stat.pos_zero = (pos_r == '0);
    stat.rdata_gt = (rdata_r > val_r);
    stat.idx_done = (idx_r == count_r);
    stat.red_done = (k_r == '0);
    stat.out_busy = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_sum = out_sum_r;
  assign out_ovf = out_ovf_r;

endmodule

// File: design/sorted_index_weighted_sum_mod.sv
// Top level of the sorted-index weighted sum block.
// Depends on siws_pkg, siws_ctrl and siws_dp.
//
// The input stream carries one value per item in in_tdata, with in_tlast
// marking the final item of a set. Each value is placed into a sorted store
// of 1024 entries by insertion: the store is read from the back one entry
// at a time, each larger value moves up one place, and the item is written
// into the gap so opened or at the front of the store.
// After the item with in_tlast, the block emits one result item: the sum of
// each sorted value times its position, modulo 1000000007, in out_tdata, and
// in out_tuser a flag that is set when items beyond the store depth arrived
// and were dropped. Forming the result reads, multiplies and accumulates each
// stored value in turn, then reduces the sum by shifted subtractions of the
// modulus and loads the output register.
// A dropped item is discarded. in_tready is high only between items.
// The result waits in an output register while the receiver stalls; the
// next set can load meanwhile, and only a second result waits for it.
// Reset clears the element count, the overflow flag and the output valid;
// the store needs no clearing.
module sorted_index_weighted_sum_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value, [31] zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [29:0] weighted_sum, [31:30] zero
  output logic        out_tuser   // [0] overflow
);

  siws_pkg::siws_cmd_t           cmd;
  siws_pkg::siws_stat_t          stat;
  logic                          in_fire;
  logic [siws_pkg::SUM_W-1:0]    sum;

  assign in_fire = in_tvalid && in_tready;

  siws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_tlast),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  siws_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_tdata[siws_pkg::VAL_W-1:0]),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_sum    (sum),
    .out_ovf    (out_tuser)
  );

  assign out_tdata = {{(32 - siws_pkg::SUM_W){1'b0}}, sum};

endmodule
